### sv/awn_pkg.sv
// Package for the affine warp block: register map, field widths and shared types.
// No dependencies; every other file of the block refers to it by scoped names.

package awn_pkg;

  // Fixed field widths.
  localparam int COEF_W  = 24;
  localparam int SHIFT_W = 32;
  localparam int SIZE_W  = 9;
  localparam int POS_W   = 8;
  localparam int PIX_W   = 24;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 32;

  // Request kinds carried by the mode field.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_INV_XX        = 3'd0,
    REG_INV_XY        = 3'd1,
    REG_INV_YX        = 3'd2,
    REG_INV_YY        = 3'd3,
    REG_SHIFT_X       = 3'd4,
    REG_SHIFT_Y       = 3'd5,
    REG_SOURCE_WIDTH  = 3'd6,
    REG_SOURCE_HEIGHT = 3'd7
  } reg_idx_e;

  // Register values after reset.
  localparam logic signed [COEF_W-1:0]  INV_DIAG_RST  = 24'sd65536;
  localparam logic signed [COEF_W-1:0]  INV_OFF_RST   = 24'sd0;
  localparam logic signed [SHIFT_W-1:0] SHIFT_RST     = 32'sd0;
  localparam logic [SIZE_W-1:0]         SIZE_RST      = 9'd256;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic signed [COEF_W-1:0]  inv_xx;
    logic signed [COEF_W-1:0]  inv_xy;
    logic signed [COEF_W-1:0]  inv_yx;
    logic signed [COEF_W-1:0]  inv_yy;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic [SIZE_W-1:0]         source_width;
    logic [SIZE_W-1:0]         source_height;
  } cfg_t;

  // Frame store access controls for one cycle.
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

### sv/awn_regs.sv
// Configuration register file of the affine warp block.
// Depends on awn_pkg for the register map and the cfg_t type.

module awn_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [awn_pkg::IDX_W-1:0] wr_index,
  input  logic [awn_pkg::DATA_W-1:0] wr_data,
  output awn_pkg::cfg_t             cfg
);

  // Register writes; an index is decoded once and the data sliced to the register width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_xx        <= awn_pkg::INV_DIAG_RST;
      cfg.inv_xy        <= awn_pkg::INV_OFF_RST;
      cfg.inv_yx        <= awn_pkg::INV_OFF_RST;
      cfg.inv_yy        <= awn_pkg::INV_DIAG_RST;
      cfg.shift_x       <= awn_pkg::SHIFT_RST;
      cfg.shift_y       <= awn_pkg::SHIFT_RST;
      cfg.source_width  <= awn_pkg::SIZE_RST;
      cfg.source_height <= awn_pkg::SIZE_RST;
    end else if (wr_en) begin
      case (awn_pkg::reg_idx_e'(wr_index))
        awn_pkg::REG_INV_XX:        cfg.inv_xx <= wr_data[awn_pkg::COEF_W-1:0];
        awn_pkg::REG_INV_XY:        cfg.inv_xy <= wr_data[awn_pkg::COEF_W-1:0];
        awn_pkg::REG_INV_YX:        cfg.inv_yx <= wr_data[awn_pkg::COEF_W-1:0];
        awn_pkg::REG_INV_YY:        cfg.inv_yy <= wr_data[awn_pkg::COEF_W-1:0];
        awn_pkg::REG_SHIFT_X:       cfg.shift_x <= wr_data[awn_pkg::SHIFT_W-1:0];
        awn_pkg::REG_SHIFT_Y:       cfg.shift_y <= wr_data[awn_pkg::SHIFT_W-1:0];
        awn_pkg::REG_SOURCE_WIDTH:  cfg.source_width <= wr_data[awn_pkg::SIZE_W-1:0];
        awn_pkg::REG_SOURCE_HEIGHT: cfg.source_height <= wr_data[awn_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/awn_frame.sv
// Frame store of the affine warp block: one synchronous RAM, one access per cycle.
// Depends on awn_pkg for the access control type and the pixel width.

module awn_frame #(
  parameter int AW = 16
) (
  input  logic                     clk,
  input  awn_pkg::mem_ctl_t        ctl,
  input  logic [AW-1:0]            addr,
  input  logic [awn_pkg::PIX_W-1:0] wdata,
  output logic [awn_pkg::PIX_W-1:0] rdata
);

  logic [awn_pkg::PIX_W-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

### sv/awn_map.sv
// Coordinate pipeline of the affine warp block: multiply, sum, truncate, bound check
// and frame store access. Depends on awn_pkg for cfg_t, mem_ctl_t and field widths.

module awn_map #(
  parameter int IMAGE_DIM = 256,
  parameter int FRAC_BITS = 16,
  parameter int CW        = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  awn_pkg::cfg_t             cfg,
  input  logic                      accept,
  input  logic                      mode,
  input  logic [awn_pkg::POS_W-1:0] pos_x,
  input  logic [awn_pkg::POS_W-1:0] pos_y,
  input  logic [awn_pkg::PIX_W-1:0] pixel_in,
  output awn_pkg::mem_ctl_t         mem_ctl,
  output logic [2*CW-1:0]           mem_addr,
  output logic [awn_pkg::PIX_W-1:0] mem_wdata,
  output logic                      res_valid,
  output logic                      res_inside
);

  localparam int PROD_W = awn_pkg::COEF_W + awn_pkg::POS_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int QW     = ACC_W - FRAC_BITS;
  localparam int DIM_W  = $clog2(IMAGE_DIM + 1) + 1;
  localparam int LW0    = (QW > DIM_W) ? QW : DIM_W;
  localparam int LW     = (LW0 > awn_pkg::SIZE_W + 1) ? LW0 : awn_pkg::SIZE_W + 1;

  // Stage 1: products and load address.
  logic                        s1_valid, s1_mode, s1_wok;
  logic [CW-1:0]               s1_col, s1_row;
  logic [awn_pkg::PIX_W-1:0]   s1_pix;
  logic signed [PROD_W-1:0]    s1_pxx, s1_pxy, s1_pyx, s1_pyy;
  // Stage 2: sums.
  logic                        s2_valid, s2_mode, s2_wok;
  logic [CW-1:0]               s2_col, s2_row;
  logic [awn_pkg::PIX_W-1:0]   s2_pix;
  logic signed [ACC_W-1:0]     s2_acc_x, s2_acc_y;
  // Stage 3: source coordinates.
  logic                        s3_valid, s3_mode, s3_wok;
  logic [CW-1:0]               s3_col, s3_row;
  logic [awn_pkg::PIX_W-1:0]   s3_pix;
  logic signed [QW-1:0]        s3_q_x, s3_q_y;

  logic signed [awn_pkg::POS_W:0] xs, ys;
  logic                           load_ok;
  logic                           rnd_x, rnd_y;
  logic signed [QW-1:0]           q_x_next, q_y_next;
  logic signed [LW-1:0]           sx_l, sy_l, w_lim, h_lim;
  logic                           in_src;
  logic                           s3_load, s3_query;

  assign xs = $signed({1'b0, pos_x});
  assign ys = $signed({1'b0, pos_y});
  assign load_ok = (int'(pos_x) < IMAGE_DIM) && (int'(pos_y) < IMAGE_DIM);

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= accept;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      res_valid <= s3_query;
    end
  end

  // Stage 1 payload: one 24x9 product per matrix entry.
  always_ff @(posedge clk) begin
    s1_mode <= mode;
    s1_wok  <= load_ok;
    s1_col  <= CW'(pos_x);
    s1_row  <= CW'(pos_y);
    s1_pix  <= pixel_in;
    s1_pxx  <= cfg.inv_xx * xs;
    s1_pxy  <= cfg.inv_xy * ys;
    s1_pyx  <= cfg.inv_yx * xs;
    s1_pyy  <= cfg.inv_yy * ys;
  end

  // Stage 2 payload: sum the products and subtract the translation.
  always_ff @(posedge clk) begin
    s2_mode  <= s1_mode;
    s2_wok   <= s1_wok;
    s2_col   <= s1_col;
    s2_row   <= s1_row;
    s2_pix   <= s1_pix;
    s2_acc_x <= ACC_W'(s1_pxx) + ACC_W'(s1_pxy) - ACC_W'(cfg.shift_x);
    s2_acc_y <= ACC_W'(s1_pyx) + ACC_W'(s1_pyy) - ACC_W'(cfg.shift_y);
  end

  // Shift out the fraction; a negative sum with a nonzero fraction rounds up toward zero.
  always_comb begin
    rnd_x    = s2_acc_x[ACC_W-1] && (|s2_acc_x[FRAC_BITS-1:0]);
    rnd_y    = s2_acc_y[ACC_W-1] && (|s2_acc_y[FRAC_BITS-1:0]);
    q_x_next = s2_acc_x[ACC_W-1:FRAC_BITS] + QW'(rnd_x);
    q_y_next = s2_acc_y[ACC_W-1:FRAC_BITS] + QW'(rnd_y);
  end

  always_ff @(posedge clk) begin
    s3_mode <= s2_mode;
    s3_wok  <= s2_wok;
    s3_col  <= s2_col;
    s3_row  <= s2_row;
    s3_pix  <= s2_pix;
    s3_q_x  <= q_x_next;
    s3_q_y  <= q_y_next;
  end

  // Bound check against the source size, limited to the store size.
  always_comb begin
    sx_l   = LW'(s3_q_x);
    sy_l   = LW'(s3_q_y);
    w_lim  = (LW'(cfg.source_width) > LW'(IMAGE_DIM)) ? LW'(IMAGE_DIM)
                                                       : LW'(cfg.source_width);
    h_lim  = (LW'(cfg.source_height) > LW'(IMAGE_DIM)) ? LW'(IMAGE_DIM)
                                                        : LW'(cfg.source_height);
    in_src = !sx_l[LW-1] && (sx_l < w_lim) && !sy_l[LW-1] && (sy_l < h_lim);
  end

  // Frame store access. Loads and queries reach the store in request order at the
  // same stage, so a query always sees exactly the loads requested before it.
  always_comb begin
    s3_load    = s3_valid && (s3_mode == awn_pkg::MODE_LOAD);
    s3_query   = s3_valid && (s3_mode == awn_pkg::MODE_QUERY);
    mem_ctl.wr = s3_load && s3_wok;
    mem_ctl.rd = s3_query && in_src;
    mem_wdata  = s3_pix;
    if (s3_mode == awn_pkg::MODE_LOAD) begin
      mem_addr = {s3_row, s3_col};
    end else begin
      mem_addr = {CW'(s3_q_y), CW'(s3_q_x)};
    end
  end

  always_ff @(posedge clk) begin
    res_inside <= in_src;
  end

endmodule

### sv/affine_warp_nearest_top.sv
// Top level of the affine warp block (inverse mapping, nearest-pixel sampling).
// Depends on awn_pkg, awn_regs, awn_map and awn_frame.
//
// Use:
//   Requests enter on start while busy is low. A request with mode load writes
//   pixel_in into the frame store at column pos_x, row pos_y (ignored when
//   outside the store). A request with mode query maps (pos_x, pos_y) back to a
//   source point through the inverse matrix and translation, truncating toward
//   zero, and returns the stored pixel with inside_res set, or zero with
//   inside_res clear when the point lies outside the source size.
//   A query's result sits on pixel_out and inside_res for one cycle with done
//   high, registered after the multiply, sum, truncate and store access stages.
//   A load gives no result.
//   One request per cycle is taken without pause outside reset: the four
//   pipeline stages (multiply, sum, truncate, store access) each hold one
//   request, and the single store port serves one load or one query read per
//   cycle. The receiver cannot stall; results are never held back.
//   Registers are written through wr_en, wr_index and wr_data, by the user only
//   while no request is in flight; the block does not check. Reset restores
//   the register defaults and empties the pipeline; busy is high during reset.
//   The frame store is not cleared and holds undefined data until loaded.

module affine_warp_nearest_top #(
  parameter int IMAGE_DIM = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic [awn_pkg::POS_W-1:0]  pos_x,
  input  logic [awn_pkg::POS_W-1:0]  pos_y,
  input  logic [awn_pkg::PIX_W-1:0]  pixel_in,
  output logic                       done,
  output logic [awn_pkg::PIX_W-1:0]  pixel_out,
  output logic                       inside_res,
  input  logic                       wr_en,
  input  logic [awn_pkg::IDX_W-1:0]  wr_index,
  input  logic [awn_pkg::DATA_W-1:0] wr_data
);

  localparam int CW = (IMAGE_DIM > 1) ? $clog2(IMAGE_DIM) : 1;
  localparam int AW = 2 * CW;

  awn_pkg::cfg_t             cfg;
  awn_pkg::mem_ctl_t         mem_ctl;
  logic [AW-1:0]             mem_addr;
  logic [awn_pkg::PIX_W-1:0] mem_wdata;
  logic [awn_pkg::PIX_W-1:0] mem_rdata;
  logic                      res_inside;
  logic                      accept;

  // The pipeline takes a request every cycle outside reset.
  assign busy   = rst;
  assign accept = start && !busy;

  awn_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  awn_map #(
    .IMAGE_DIM (IMAGE_DIM),
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW)
  ) u_map (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .mode       (mode),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_in   (pixel_in),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .res_valid  (done),
    .res_inside (res_inside)
  );

  awn_frame #(
    .AW (AW)
  ) u_frame (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Points outside the source read as black.
  assign pixel_out  = res_inside ? mem_rdata : '0;
  assign inside_res = res_inside;

endmodule

### sv/awn_check.sv
// Port-level checker for the affine warp block, bound to the top level.
// Depends on awn_pkg for field widths and request kinds.

module awn_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       mode,
  input logic                       done,
  input logic [awn_pkg::PIX_W-1:0]  pixel_out,
  input logic                       inside_res
);

  // Every query that is taken gives a result.
  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == awn_pkg::MODE_QUERY)) |-> ##4 done)
    else $error("query without result");

  // A load never gives a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == awn_pkg::MODE_LOAD)) |-> ##4 !done)
    else $error("load produced a result");

  // Every result belongs to a query taken earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (mode == awn_pkg::MODE_QUERY), 4))
    else $error("result without query");

  // An outside point returns black.
  a_outside_black: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_res) |-> (pixel_out == '0))
    else $error("outside point returned nonzero pixel");

endmodule

bind affine_warp_nearest_top awn_check u_check (.*);
